// File: rtl/core/synth_voice_allocator_macros.svh
// Assertion macros shared by the voice allocator RTL.
`ifndef SYNTH_VOICE_ALLOCATOR_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_MACROS_SVH

// expression must never hold outside reset
`define SVALLOC_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

// same-cycle implication
`define SVALLOC_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SVALLOC_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/svalloc_pkg.sv
// Types, constants and control/status structs of the voice allocator.
`default_nettype none
package svalloc_pkg;

   localparam int VOICE_COUNT   = 32;
   localparam int VIDX_W        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int VOICE_FIELD_W = 5;
   localparam int NOTE_SLOTS    = 128;
   localparam int NOTE_W        = 7;
   localparam int HCNT_W        = 8;
   localparam int UNI_W         = 6;
   localparam int Q16_W         = 16;
   localparam int MAX_UNISON    = 32;

   localparam int DIV_W  = 24;
   localparam int MAG_W  = DIV_W - 1;
   localparam int DVS_W  = 6;
   localparam int DCNT_W = $clog2(MAG_W + 1);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [Q16_W-1:0] PAN_CENTRE = 16'h8000;
   localparam logic [Q16_W-1:0] Q16_MAX    = 16'hFFFF;

   localparam logic [1:0] EV_NOTE_ON  = 2'd0;
   localparam logic [1:0] EV_NOTE_OFF = 2'd1;
   localparam logic [1:0] EV_FINISHED = 2'd2;
   localparam logic [1:0] EV_ALL_OFF  = 2'd3;

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_SLIDE   = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_VOICE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNISON     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DETUNE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN        = 2'd3;

   localparam logic [1:0] JOB_DET_BASE = 2'd0;
   localparam logic [1:0] JOB_DET_STEP = 2'd1;
   localparam logic [1:0] JOB_PAN_BASE = 2'd2;
   localparam logic [1:0] JOB_PAN_STEP = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_DIV, ST_SCAN, ST_HRD, ST_HCHK, ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      SCAN_START, SCAN_SLIDE, SCAN_REL_NOTE, SCAN_REL_ALL
   } scan_type;

   typedef struct packed {
      logic       accept;
      logic       div_start;
      logic [1:0] next_job;
      logic       div_load;
      logic [1:0] job;
      logic       scan_init;
      logic       scan_step;
      scan_type   kind;
      logic       tgt_hist;
      logic       hist_read;
      logic       hist_dec;
      logic       mono_stop;
      logic       flush;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] ev_mode;
      logic       voice_mode;
      logic       mono_playing;
      logic       hist_empty;
      logic       hist_one;
      logic       hist_match;
      logic       hist_held;
      logic       div_done;
      logic       scan_ok;
      logic       scan_end;
      logic       pend_valid;
      logic       out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// File: rtl/core/svalloc_div.sv
// Bit-serial signed floor divider, small unsigned divisor.
`default_nettype none
module svalloc_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [svalloc_pkg::DIV_W-1:0]  dividend,
   input  logic        [svalloc_pkg::DVS_W-1:0]  divisor,
   output logic                                  done,
   output logic signed [svalloc_pkg::DIV_W-1:0]  quotient,
   output logic        [svalloc_pkg::DVS_W-1:0]  remainder
);
   import svalloc_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [MAG_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic              neg_ff;

   logic [DVS_W:0]    trial;
   logic              ge;
   logic [DVS_W-1:0]  rem_in;
   logic [DIV_W-1:0]  abs_in;
   logic signed [DIV_W-1:0] q_mag;

   assign abs_in = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
   assign trial  = {rem_ff, mag_ff[MAG_W-1]};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign rem_in = ge ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(MAG_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= abs_in[MAG_W-1:0];
         quo_ff <= '0;
         rem_ff <= '0;
         dvs_ff <= divisor;
         neg_ff <= dividend[DIV_W-1];
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[MAG_W-2:0], 1'b0};
         quo_ff <= {quo_ff[MAG_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign q_mag = $signed({1'b0, quo_ff});
   assign done  = done_ff;

   always_comb begin
      quotient  = q_mag;
      remainder = rem_ff;
      if (neg_ff) begin
         if (rem_ff != '0) begin
            quotient  = -(q_mag + DIV_W'(1));
            remainder = dvs_ff - rem_ff;
         end else begin
            quotient  = -q_mag;
            remainder = '0;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/svalloc_ctrl.sv
// Sequencer of the voice allocator: event decode, division jobs, scans, log walk.
`default_nettype none
module svalloc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  svalloc_pkg::dp_status_type st,
   output svalloc_pkg::dp_cmd_type    cmd
);
   import svalloc_pkg::*;

   state_type  state_ff, state_in;
   scan_type   kind_ff, kind_in;
   logic       first_ff, first_in;
   logic [1:0] job_ff, job_in;
   logic       hist_go;

   assign hist_go = !(first_ff && !st.hist_match);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= SCAN_START;
         first_ff <= 1'b0;
         job_ff   <= JOB_DET_BASE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         first_ff <= first_in;
         job_ff   <= job_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      first_in = first_ff;
      job_in   = job_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (st.ev_mode)
                  EV_NOTE_ON: begin
                     if (!st.voice_mode || !st.mono_playing) begin
                        state_in = ST_PREP;
                        kind_in  = SCAN_START;
                     end else begin
                        state_in = ST_SCAN;
                        kind_in  = SCAN_SLIDE;
                     end
                  end
                  EV_NOTE_OFF: begin
                     if (!st.voice_mode) begin
                        state_in = ST_SCAN;
                        kind_in  = SCAN_REL_NOTE;
                     end else if (!st.hist_empty) begin
                        state_in = ST_HRD;
                        first_in = 1'b1;
                     end
                  end
                  EV_ALL_OFF: begin
                     state_in = ST_SCAN;
                     kind_in  = SCAN_REL_ALL;
                  end
                  default: ;
               endcase
            end
         end
         ST_PREP: begin
            state_in = ST_DIV;
            job_in   = JOB_DET_BASE;
         end
         ST_DIV: begin
            if (st.div_done) begin
               if (job_ff == JOB_PAN_STEP) begin
                  state_in = ST_SCAN;
               end else begin
                  job_in = job_ff + 2'd1;
               end
            end
         end
         ST_SCAN: begin
            if (st.scan_ok && st.scan_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_HRD: begin
            state_in = ST_HCHK;
         end
         ST_HCHK: begin
            first_in = 1'b0;
            if (!hist_go) begin
               state_in = ST_IDLE;
            end else if (st.hist_held) begin
               state_in = ST_SCAN;
               kind_in  = SCAN_SLIDE;
            end else if (st.hist_one) begin
               state_in = ST_SCAN;
               kind_in  = SCAN_REL_ALL;
            end else begin
               state_in = ST_HRD;
            end
         end
         ST_FLUSH: begin
            if (!st.pend_valid || st.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.kind   = kind_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.accept    = req_tvalid;
            cmd.scan_init = req_tvalid;
         end
         ST_PREP: begin
            cmd.div_start = 1'b1;
            cmd.next_job  = JOB_DET_BASE;
         end
         ST_DIV: begin
            if (st.div_done) begin
               cmd.div_load = 1'b1;
               cmd.job      = job_ff;
               if (job_ff != JOB_PAN_STEP) begin
                  cmd.div_start = 1'b1;
                  cmd.next_job  = job_ff + 2'd1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_HRD: begin
            cmd.hist_read = 1'b1;
         end
         ST_HCHK: begin
            if (hist_go) begin
               if (st.hist_held) begin
                  cmd.scan_init = 1'b1;
                  cmd.tgt_hist  = 1'b1;
               end else begin
                  cmd.hist_dec = 1'b1;
                  if (st.hist_one) begin
                     cmd.mono_stop = 1'b1;
                     cmd.scan_init = 1'b1;
                  end
               end
            end
         end
         ST_FLUSH: begin
            cmd.flush = st.pend_valid && st.out_free;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/svalloc_dpath.sv
// Datapath: voice table, held-note map, note log, unison steppers, result stages.
`default_nettype none
module svalloc_dpath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  svalloc_pkg::dp_cmd_type                  cmd,
   output svalloc_pkg::dp_status_type               st,
   input  logic [svalloc_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic [1:0]                               req_tuser,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [svalloc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [svalloc_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [svalloc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [1:0]                               rsp_tuser,
   output logic                                     rsp_tlast
);
   import svalloc_pkg::*;

   // configuration
   logic             vmode_ff;
   logic [UNI_W-1:0] unison_ff;
   logic [Q16_W-1:0] detune_ff;
   logic [Q16_W-1:0] pan_ff;

   // voice and note state
   logic [VOICE_COUNT-1:0] busy_ff;
   logic [NOTE_W-1:0]      pitch_ff [VOICE_COUNT];
   logic [NOTE_SLOTS-1:0]  held_ff;
   logic [NOTE_W-1:0]      hist_mem [NOTE_SLOTS];
   logic [HCNT_W-1:0]      hist_cnt_ff;
   logic [NOTE_W-1:0]      hist_rd_ff;
   logic                   playing_ff;

   // current event
   logic [NOTE_W-1:0] note_ff;
   logic [NOTE_W-1:0] vel_ff;
   logic [NOTE_W-1:0] tgt_ff;
   logic [VIDX_W-1:0] k_ff;
   logic [UNI_W-1:0]  rem_ff;

   // unison steppers
   logic signed [DIV_W-1:0] qdet_ff, dqdet_ff, qpan_ff, dqpan_ff;
   logic [DVS_W-1:0]        rdet_ff, drdet_ff, rpan_ff, drpan_ff;

   // pending and output result
   logic                     pend_valid_ff;
   logic [VOICE_FIELD_W-1:0] pend_voice_ff, out_voice_ff;
   logic [1:0]               pend_cmd_ff, out_cmd_ff;
   logic [NOTE_W-1:0]        pend_tgt_ff, out_tgt_ff;
   logic [NOTE_W-1:0]        pend_vel_ff, out_vel_ff;
   logic [Q16_W-1:0]         pend_det_ff, out_det_ff;
   logic [Q16_W-1:0]         pend_pan_ff, out_pan_ff;
   logic                     out_last_ff;
   logic                     out_valid_ff, out_valid_in;

   // request fields
   logic [NOTE_W-1:0] req_note, req_vel;
   logic [4:0]        req_vid;

   // unison set geometry and division operands
   logic [UNI_W-1:0]        u_cl, d_val;
   logic [DVS_W-1:0]        m_val;
   logic [4:0]              jtop;
   logic [20:0]             det_prod;
   logic signed [DIV_W-1:0] det_base, det_step, pan_base, pan_step;
   logic signed [16:0]      pan_off;
   logic signed [6:0]       pan_coef;
   logic signed [DIV_W-1:0] pan_prod, pan_v;
   logic signed [DIV_W-1:0] div_dividend, div_q;
   logic [DVS_W-1:0]        div_r;
   logic                    div_done;

   // scan
   logic                    busy_k, hit, step_go, out_load;
   logic [NOTE_W-1:0]       pitch_k;
   logic [1:0]              new_cmd;
   logic [NOTE_W-1:0]       new_tgt, new_vel;
   logic [Q16_W-1:0]        new_det, new_pan;
   logic signed [DIV_W-1:0] qdet_in, qpan_in;
   logic [DVS_W-1:0]        rdet_in, rpan_in;
   logic [DVS_W:0]          rdet_sum, rpan_sum;

   assign req_note = req_tdata[6:0];
   assign req_vel  = req_tdata[13:7];
   assign req_vid  = req_tdata[18:14];

   assign csr_ready = 1'b1;

   always_comb begin
      if (unison_ff == '0) begin
         u_cl = UNI_W'(1);
      end else if (unison_ff > UNI_W'(MAX_UNISON)) begin
         u_cl = UNI_W'(MAX_UNISON);
      end else begin
         u_cl = unison_ff;
      end
   end

   assign d_val    = (u_cl > UNI_W'(1)) ? (u_cl - UNI_W'(1)) : UNI_W'(1);
   assign m_val    = DVS_W'({d_val, 1'b0});
   assign jtop     = 5'(u_cl - UNI_W'(1));
   assign det_prod = 21'(jtop) * 21'(detune_ff);
   assign det_base = $signed({2'b00, det_prod, 1'b0}) + $signed({18'b0, d_val});
   assign det_step = -$signed({7'b0, detune_ff, 1'b0});
   assign pan_off  = $signed({1'b0, pan_ff}) - $signed({1'b0, PAN_CENTRE});
   assign pan_coef = $signed({1'b0, jtop, 1'b0}) - $signed({1'b0, d_val});
   assign pan_prod = DIV_W'(pan_coef) * DIV_W'(pan_off);
   assign pan_v    = pan_prod + $signed({3'b0, d_val, 15'b0});
   assign pan_base = (pan_v <<< 1) + $signed({18'b0, d_val});
   assign pan_step = -(DIV_W'(pan_off) <<< 2);

   always_comb begin
      case (cmd.next_job)
         JOB_DET_BASE: div_dividend = det_base;
         JOB_DET_STEP: div_dividend = det_step;
         JOB_PAN_BASE: div_dividend = pan_base;
         JOB_PAN_STEP: div_dividend = pan_step;
         default:      div_dividend = det_base;
      endcase
   end

   svalloc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (m_val),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // scan of the voice table
   assign busy_k  = busy_ff[k_ff];
   assign pitch_k = pitch_ff[k_ff];

   always_comb begin
      case (cmd.kind)
         SCAN_START:    hit = !busy_k && (rem_ff != '0);
         SCAN_SLIDE:    hit = busy_k;
         SCAN_REL_NOTE: hit = busy_k && (pitch_k == tgt_ff);
         SCAN_REL_ALL:  hit = busy_k;
         default:       hit = 1'b0;
      endcase
   end

   always_comb begin
      new_tgt = tgt_ff;
      new_vel = '0;
      new_det = '0;
      new_pan = '0;
      case (cmd.kind)
         SCAN_START: begin
            new_cmd = CMD_START;
            new_vel = vel_ff;
            if (qdet_ff < 0) begin
               new_det = '0;
            end else if (qdet_ff > $signed({8'b0, Q16_MAX})) begin
               new_det = Q16_MAX;
            end else begin
               new_det = qdet_ff[Q16_W-1:0];
            end
            if (qpan_ff < 0) begin
               new_pan = '0;
            end else if (qpan_ff > $signed({8'b0, Q16_MAX})) begin
               new_pan = Q16_MAX;
            end else begin
               new_pan = qpan_ff[Q16_W-1:0];
            end
         end
         SCAN_SLIDE:    new_cmd = CMD_SLIDE;
         SCAN_REL_NOTE: new_cmd = CMD_RELEASE;
         SCAN_REL_ALL: begin
            new_cmd = CMD_RELEASE;
            new_tgt = pitch_k;
         end
         default:       new_cmd = CMD_RELEASE;
      endcase
   end

   // one unison position down: add the step, carry the remainder
   assign rdet_sum = {1'b0, rdet_ff} + {1'b0, drdet_ff};
   assign rpan_sum = {1'b0, rpan_ff} + {1'b0, drpan_ff};

   always_comb begin
      qdet_in = qdet_ff + dqdet_ff;
      rdet_in = rdet_sum[DVS_W-1:0];
      if (rdet_sum >= {1'b0, m_val}) begin
         qdet_in = qdet_ff + dqdet_ff + DIV_W'(1);
         rdet_in = DVS_W'(rdet_sum - {1'b0, m_val});
      end
      qpan_in = qpan_ff + dqpan_ff;
      rpan_in = rpan_sum[DVS_W-1:0];
      if (rpan_sum >= {1'b0, m_val}) begin
         qpan_in = qpan_ff + dqpan_ff + DIV_W'(1);
         rpan_in = DVS_W'(rpan_sum - {1'b0, m_val});
      end
   end

   assign step_go      = cmd.scan_step && st.scan_ok;
   assign out_load     = (step_go && hit && pend_valid_ff) || cmd.flush;
   assign out_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vmode_ff      <= 1'b0;
         unison_ff     <= UNI_W'(1);
         detune_ff     <= '0;
         pan_ff        <= PAN_CENTRE;
         busy_ff       <= '0;
         held_ff       <= '0;
         hist_cnt_ff   <= '0;
         playing_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.accept) begin
            case (req_tuser)
               EV_NOTE_ON: begin
                  if (vmode_ff) begin
                     held_ff[req_note] <= 1'b1;
                     if (hist_cnt_ff < HCNT_W'(NOTE_SLOTS)) begin
                        hist_cnt_ff <= hist_cnt_ff + 1'b1;
                     end
                     playing_ff <= 1'b1;
                  end
               end
               EV_NOTE_OFF: begin
                  if (vmode_ff && (hist_cnt_ff != '0)) begin
                     held_ff[req_note] <= 1'b0;
                  end
               end
               EV_FINISHED: begin
                  if ({1'b0, req_vid} < 6'(VOICE_COUNT)) begin
                     busy_ff[VIDX_W'(req_vid)] <= 1'b0;
                  end
               end
               EV_ALL_OFF: begin
                  playing_ff  <= 1'b0;
                  hist_cnt_ff <= '0;
                  held_ff     <= '0;
               end
               default: ;
            endcase
         end
         if (cmd.hist_dec) begin
            hist_cnt_ff <= hist_cnt_ff - 1'b1;
         end
         if (cmd.mono_stop) begin
            playing_ff <= 1'b0;
            held_ff    <= '0;
         end
         if (step_go && hit && (cmd.kind == SCAN_START)) begin
            busy_ff[k_ff] <= 1'b1;
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end else if (step_go && hit) begin
            pend_valid_ff <= 1'b1;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_VOICE_MODE: begin
                  vmode_ff    <= csr_data[0];
                  busy_ff     <= '0;
                  held_ff     <= '0;
                  hist_cnt_ff <= '0;
                  playing_ff  <= 1'b0;
               end
               CSR_UNISON: unison_ff <= csr_data[UNI_W-1:0];
               CSR_DETUNE: detune_ff <= csr_data;
               CSR_PAN:    pan_ff    <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // note log
   always_ff @(posedge clock) begin
      if (cmd.accept && vmode_ff && (req_tuser == EV_NOTE_ON) &&
          (hist_cnt_ff < HCNT_W'(NOTE_SLOTS))) begin
         hist_mem[hist_cnt_ff[NOTE_W-1:0]] <= req_note;
      end
      if (cmd.hist_read) begin
         hist_rd_ff <= hist_mem[NOTE_W'(hist_cnt_ff - 1'b1)];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         note_ff <= req_note;
         vel_ff  <= req_vel;
         tgt_ff  <= req_note;
      end
      if (cmd.tgt_hist) begin
         tgt_ff <= hist_rd_ff;
      end
      if (cmd.scan_init) begin
         k_ff   <= '0;
         rem_ff <= u_cl;
      end else if (step_go) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.div_load) begin
         case (cmd.job)
            JOB_DET_BASE: begin
               qdet_ff <= div_q;
               rdet_ff <= div_r;
            end
            JOB_DET_STEP: begin
               dqdet_ff <= div_q;
               drdet_ff <= div_r;
            end
            JOB_PAN_BASE: begin
               qpan_ff <= div_q;
               rpan_ff <= div_r;
            end
            JOB_PAN_STEP: begin
               dqpan_ff <= div_q;
               drpan_ff <= div_r;
            end
            default: ;
         endcase
      end
      if (step_go && hit) begin
         case (cmd.kind)
            SCAN_START: begin
               pitch_ff[k_ff] <= tgt_ff;
               rem_ff         <= rem_ff - 1'b1;
               qdet_ff        <= qdet_in;
               rdet_ff        <= rdet_in;
               qpan_ff        <= qpan_in;
               rpan_ff        <= rpan_in;
            end
            SCAN_SLIDE: pitch_ff[k_ff] <= tgt_ff;
            default: ;
         endcase
         pend_voice_ff <= VOICE_FIELD_W'(k_ff);
         pend_cmd_ff   <= new_cmd;
         pend_tgt_ff   <= new_tgt;
         pend_vel_ff   <= new_vel;
         pend_det_ff   <= new_det;
         pend_pan_ff   <= new_pan;
      end
      if (out_load) begin
         out_voice_ff <= pend_voice_ff;
         out_cmd_ff   <= pend_cmd_ff;
         out_tgt_ff   <= pend_tgt_ff;
         out_vel_ff   <= pend_vel_ff;
         out_det_ff   <= pend_det_ff;
         out_pan_ff   <= pend_pan_ff;
         out_last_ff  <= cmd.flush;
      end
   end

   assign st.ev_mode      = req_tuser;
   assign st.voice_mode   = vmode_ff;
   assign st.mono_playing = playing_ff;
   assign st.hist_empty   = (hist_cnt_ff == '0);
   assign st.hist_one     = (hist_cnt_ff == HCNT_W'(1));
   assign st.hist_match   = (hist_rd_ff == note_ff);
   assign st.hist_held    = held_ff[hist_rd_ff];
   assign st.div_done     = div_done;
   assign st.out_free     = !out_valid_ff || rsp_tready;
   assign st.scan_ok      = !(hit && pend_valid_ff && !st.out_free);
   assign st.scan_end     = (k_ff == VIDX_W'(VOICE_COUNT - 1));
   assign st.pend_valid   = pend_valid_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_cmd_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'b0, out_pan_ff, out_det_ff, out_vel_ff, out_tgt_ff, out_voice_ff};

endmodule
`default_nettype wire

// File: rtl/core/synth_voice_allocator.sv
// Voice allocator top level: sequencer plus datapath.
//
// Turns note events into per-voice start, slide and release beats. Each event is
// taken one at a time. Note-on, all-off and poly note-off events are walked
// through a scan of all 32 voices, one voice per cycle unless the result port
// stalls. A note-on that starts voices first runs four 23-bit serial divisions
// to set up the detune and pan steppers. A mono note-off walks the note log back,
// through a read state and a check state per entry, before any scan;
// voice-finished events need no scan. A stalled result port holds the scan.
// Configuration writes are always taken.
`default_nettype none
module synth_voice_allocator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // note[6:0], velocity[13:7], voice_id[18:14]
   input  logic [svalloc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode[1:0]
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // voice[4:0], target_note[11:5], start_velocity[18:12],
   // voice_detune[34:19], voice_pan[50:35]
   output logic [svalloc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // command[1:0]
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [svalloc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [svalloc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import svalloc_pkg::*;

`include "synth_voice_allocator_macros.svh"

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          rsp_plain;
   logic          mode_write;
   logic          dp_cleared;

   svalloc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (dp_status),
      .cmd        (dp_cmd)
   );

   svalloc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .st         (dp_status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_plain  = rsp_tvalid && (rsp_tuser != CMD_START);
   assign mode_write = csr_valid && (csr_index == CSR_VOICE_MODE);
   assign dp_cleared = dp_status.hist_empty && !dp_status.mono_playing;

   `SVALLOC_NEVER(a_idle_no_pend, req_tready && dp_status.pend_valid, "beat pending in idle")
   `SVALLOC_IMPLY(a_plain_fields, rsp_plain, rsp_tdata[50:12] == '0, "plain beat has payload")
   `SVALLOC_NEXT(a_mode_clears, mode_write, dp_cleared, "voice mode write kept state")

endmodule
`default_nettype wire

// File: verif/synth_voice_allocator_chk.sv
// Checker for the voice allocator: predicts command beats from observed events and compares.
module synth_voice_allocator_chk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [svalloc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                         req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [svalloc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]                         rsp_tuser,
   input  logic                               rsp_tlast,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [svalloc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [svalloc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                 fail_count,
   output int                                 pending
);
   import svalloc_pkg::*;

   typedef struct {
      logic [4:0]  voice;
      logic [1:0]  cmd;
      logic [6:0]  note;
      logic [6:0]  vel;
      logic [15:0] det;
      logic [15:0] pan;
      logic        last;
   } voice_cmd_type;

   voice_cmd_type cmd_q[$];
   voice_cmd_type ev_cmds[$];

   bit          busy[VOICE_COUNT];
   bit [6:0]    pitch[VOICE_COUNT];
   bit          held[NOTE_SLOTS];
   bit [6:0]    note_log[NOTE_SLOTS];
   int unsigned log_len;
   bit          mono_on;
   bit          mono_mode;
   bit [5:0]    unison;
   bit [15:0]   detune_amt;
   bit [15:0]   pan_width;

   assign pending = cmd_q.size();

   function automatic void clear_voices();
      for (int k = 0; k < VOICE_COUNT; k++) begin
         busy[k] = 0;
         pitch[k] = 0;
      end
      for (int n = 0; n < NOTE_SLOTS; n++) begin
         held[n] = 0;
         note_log[n] = 0;
      end
      log_len = 0;
      mono_on = 0;
   endfunction

   function automatic void add_cmd(int v, logic [1:0] c, logic [6:0] n, logic [6:0] vl,
                                   logic [15:0] dt, logic [15:0] pn);
      voice_cmd_type b;
      if (ev_cmds.size() >= 32) return;
      b.voice = v[4:0];
      b.cmd = c;
      b.note = n;
      b.vel = vl;
      b.det = dt;
      b.pan = pn;
      b.last = 0;
      ev_cmds.push_back(b);
   endfunction

   function automatic void start_unison(logic [6:0] n, logic [6:0] vl);
      longint u, d, j, dt, pv, pn;
      u = unison;
      if (u < 1) u = 1;
      if (u > MAX_UNISON) u = MAX_UNISON;
      d = (u > 1) ? u - 1 : 1;
      j = u;
      for (int k = 0; k < VOICE_COUNT && j > 0; k++) begin
         if (!busy[k]) begin
            j--;
            dt = (2 * j * longint'(detune_amt) + d) / (2 * d);
            pv = 32768 * d + (2 * j - d) * (longint'(pan_width) - 32768);
            if (pv < 0) pv = 0;
            pn = (pv * 2 + d) / (2 * d);
            if (pn > 65535) pn = 65535;
            if (dt > 65535) dt = 65535;
            busy[k] = 1;
            pitch[k] = n;
            add_cmd(k, CMD_START, n, vl, dt[15:0], pn[15:0]);
         end
      end
   endfunction

   function automatic void slide_busy(logic [6:0] n);
      for (int k = 0; k < VOICE_COUNT; k++)
         if (busy[k]) begin
            pitch[k] = n;
            add_cmd(k, CMD_SLIDE, n, 0, 0, 0);
         end
   endfunction

   function automatic void release_busy();
      for (int k = 0; k < VOICE_COUNT; k++)
         if (busy[k]) add_cmd(k, CMD_RELEASE, pitch[k], 0, 0, 0);
   endfunction

   function automatic void predict_event(logic [1:0] ev, logic [6:0] n, logic [6:0] vl,
                                         logic [4:0] vid);
      logic [6:0] top;
      ev_cmds.delete();
      case (ev)
         EV_NOTE_ON: begin
            if (!mono_mode) start_unison(n, vl);
            else begin
               held[n] = 1;
               if (log_len < NOTE_SLOTS) begin
                  note_log[log_len] = n;
                  log_len++;
               end
               if (!mono_on) begin
                  mono_on = 1;
                  start_unison(n, vl);
               end else slide_busy(n);
            end
         end
         EV_NOTE_OFF: begin
            if (!mono_mode) begin
               for (int k = 0; k < VOICE_COUNT; k++)
                  if (busy[k] && pitch[k] == n) add_cmd(k, CMD_RELEASE, n, 0, 0, 0);
            end else if (log_len > 0) begin
               held[n] = 0;
               if (note_log[log_len - 1] == n) begin
                  while (log_len > 0) begin
                     top = note_log[log_len - 1];
                     if (held[top]) begin
                        slide_busy(top);
                        break;
                     end
                     log_len--;
                  end
                  if (log_len == 0) begin
                     mono_on = 0;
                     for (int m = 0; m < NOTE_SLOTS; m++) held[m] = 0;
                     release_busy();
                  end
               end
            end
         end
         EV_FINISHED: busy[vid] = 0;
         default: begin
            release_busy();
            mono_on = 0;
            log_len = 0;
            for (int m = 0; m < NOTE_SLOTS; m++) held[m] = 0;
         end
      endcase
      if (ev_cmds.size() > 0) ev_cmds[ev_cmds.size() - 1].last = 1;
      foreach (ev_cmds[i]) cmd_q.push_back(ev_cmds[i]);
   endfunction

   always @(posedge clock) begin
      voice_cmd_type got, want;
      if (reset) begin
         clear_voices();
         mono_mode = 0;
         unison = 1;
         detune_amt = 0;
         pan_width = 16'h8000;
         cmd_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VOICE_MODE: begin
                  mono_mode = csr_data[0];
                  clear_voices();
               end
               CSR_UNISON: unison = csr_data[5:0];
               CSR_DETUNE: detune_amt = csr_data;
               default:    pan_width = csr_data;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.voice = rsp_tdata[4:0];
            got.note  = rsp_tdata[11:5];
            got.vel   = rsp_tdata[18:12];
            got.det   = rsp_tdata[34:19];
            got.pan   = rsp_tdata[50:35];
            got.cmd   = rsp_tuser;
            got.last  = rsp_tlast;
            if (cmd_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected beat: voice %0d cmd %0d note %0d", got.voice, got.cmd,
                           got.note);
            end else begin
               want = cmd_q.pop_front();
               if (got.voice !== want.voice || got.cmd !== want.cmd ||
                   got.note !== want.note || got.vel !== want.vel ||
                   got.det !== want.det || got.pan !== want.pan || got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: exp v%0d c%0d n%0d vel%0d det%0d pan%0d l%0d",
                               " / got v%0d c%0d n%0d vel%0d det%0d pan%0d l%0d"},
                              want.voice, want.cmd, want.note, want.vel, want.det, want.pan,
                              want.last, got.voice, got.cmd, got.note, got.vel, got.det,
                              got.pan, got.last);
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_event(req_tuser, req_tdata[6:0], req_tdata[13:7], req_tdata[18:14]);
      end
   end

endmodule

// File: verif/synth_voice_allocator_tb.sv
// Testbench top for the voice allocator: clock, reset, event and register stimulus, verdict.
module synth_voice_allocator_tb;
   import svalloc_pkg::*;

   localparam int LIMIT = 2000000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    fail_count;
   int                    pending;
   int                    cycles = 0;
   int                    hold_cycles = 0;
   bit                    sender_quiet = 0;
   bit                    mono_now = 0;
   logic [6:0]            held_q[$];

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   synth_voice_allocator i_dut (.*);

   synth_voice_allocator_chk i_chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stalls, quiet stretches, and a long hold when asked
   initial begin
      int gap;
      bit quiet;
      quiet = 0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 63) == 0) quiet = !quiet;
         gap = quiet ? 0 : $urandom_range(0, 18);
         if (hold_cycles > 0) begin
            gap = hold_cycles;
            hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_VOICE_MODE) begin
         mono_now = val[0];
         held_q.delete();
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      @(posedge clock);
      wait (pending == 0);
      repeat (400) @(posedge clock);
   endtask

   task automatic set_cfg(bit md, logic [5:0] u, logic [15:0] dt, logic [15:0] pw);
      drain();
      csr_write(CSR_UNISON, 16'(u));
      csr_write(CSR_DETUNE, dt);
      csr_write(CSR_PAN, pw);
      csr_write(CSR_VOICE_MODE, 16'(md));
      csr_valid <= 0;
   endtask

   task automatic send(logic [1:0] ev, logic [6:0] n, logic [6:0] vl, logic [4:0] vid);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= ev;
      req_tdata <= {5'd0, vid, vl, n};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (ev == EV_NOTE_ON) held_q.push_back(n);
      else if (ev == EV_ALL_OFF) held_q.delete();
      else if (ev == EV_NOTE_OFF)
         foreach (held_q[i])
            if (held_q[i] == n) begin
               held_q.delete(i);
               break;
            end
   endtask

   task automatic random_event();
      int r;
      logic [6:0] n;
      r = $urandom_range(0, 99);
      n = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'(60 + $urandom_range(0, 7));
      if (r < 45) send(EV_NOTE_ON, n, 7'($urandom), 5'($urandom));
      else if (r < 75) begin
         if (held_q.size() > 0 && r < 70)
            n = mono_now && r < 62 ? held_q[held_q.size() - 1]
                                   : held_q[$urandom_range(0, held_q.size() - 1)];
         send(EV_NOTE_OFF, n, 7'($urandom), 5'($urandom));
      end else if (r < 95) send(EV_FINISHED, 7'($urandom), 7'($urandom), 5'($urandom));
      else send(EV_ALL_OFF, 7'($urandom), 7'($urandom), 5'($urandom));
   endtask

   initial begin
      logic [5:0]  uni_pick[8] = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd5, 6'd32, 6'd63, 6'd4};
      logic [15:0] q_pick[4] = '{16'd0, 16'hFFFF, 16'h8000, 16'h1234};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // polyphonic directed beats
      set_cfg(0, 1, 0, 16'h8000);
      send(EV_NOTE_ON, 0, 127, 0);
      send(EV_NOTE_ON, 127, 0, 31);
      send(EV_NOTE_OFF, 0, 0, 0);
      send(EV_NOTE_OFF, 5, 0, 0);
      send(EV_NOTE_OFF, 127, 0, 0);
      send(EV_FINISHED, 0, 0, 0);
      send(EV_FINISHED, 0, 0, 31);
      send(EV_ALL_OFF, 0, 0, 0);
      set_cfg(0, 32, 16'hFFFF, 16'h0000);
      send(EV_NOTE_ON, 64, 100, 0);
      send(EV_NOTE_ON, 65, 100, 0);
      send(EV_FINISHED, 0, 0, 3);
      send(EV_NOTE_ON, 66, 1, 0);
      send(EV_ALL_OFF, 0, 0, 0);
      set_cfg(0, 0, 16'h7FFF, 16'hFFFF);
      send(EV_NOTE_ON, 10, 10, 0);
      set_cfg(0, 63, 16'h0001, 16'h4000);
      send(EV_NOTE_ON, 11, 20, 0);

      // mono legato directed beats
      set_cfg(1, 2, 16'h1000, 16'hC000);
      send(EV_NOTE_OFF, 40, 0, 0);
      send(EV_NOTE_ON, 40, 90, 0);
      send(EV_NOTE_ON, 45, 90, 0);
      send(EV_NOTE_OFF, 45, 0, 0);
      send(EV_NOTE_ON, 47, 90, 0);
      send(EV_NOTE_OFF, 40, 0, 0);
      send(EV_NOTE_OFF, 47, 0, 0);
      send(EV_ALL_OFF, 0, 0, 0);

      // log saturation with a long result hold so the input stalls
      set_cfg(1, 1, 16'h0, 16'h8000);
      sender_quiet = 1;
      hold_cycles = 3000;
      for (int i = 0; i < 132; i++) send(EV_NOTE_ON, 7'(i), 7'(i), 0);
      sender_quiet = 0;
      send(EV_NOTE_OFF, 3, 0, 0);
      send(EV_NOTE_OFF, 127, 0, 0);
      send(EV_ALL_OFF, 0, 0, 0);

      // random phases
      for (int p = 0; p < 7; p++) begin
         set_cfg(1'(p % 2), uni_pick[$urandom_range(0, 7)],
                 ($urandom_range(0, 1) ? q_pick[$urandom_range(0, 3)] : 16'($urandom)),
                 ($urandom_range(0, 1) ? q_pick[$urandom_range(0, 3)] : 16'($urandom)));
         sender_quiet = (p == 3);
         for (int i = 0; i < 22; i++) random_event();
      end
      sender_quiet = 0;

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/svalloc_pkg.sv
rtl/core/svalloc_div.sv
rtl/core/svalloc_ctrl.sv
rtl/core/svalloc_dpath.sv
rtl/core/synth_voice_allocator.sv
verif/synth_voice_allocator_chk.sv
verif/synth_voice_allocator_tb.sv
